// ===== sv/swc_pkg.sv =====
// shared types, widths and helpers of the sphere wall collision core
package swc_pkg;

  // fraction bits of positions, velocities, radius and time
  localparam int FRAC_BITS = 16;
  // fraction bits of the wall normal
  localparam int NORM_FRAC = 16;

  // widths of the exact intermediates
  localparam int DIFF_W = 33;
  localparam int PN_W   = 51;
  localparam int VN_W   = 50;
  localparam int GN_W   = 50;
  localparam int GAP_W  = 54;
  localparam int VSUM_W = 52;
  localparam int SPD_W  = 53;
  localparam int G_W    = 53;
  localparam int S_W    = 53;
  localparam int VNQ_W  = VSUM_W + 1 - NORM_FRAC;
  localparam int NVQ_W  = VNQ_W + 18;
  localparam int ACC_W  = NVQ_W + 3;
  localparam int RND_W  = ACC_W - NORM_FRAC;

  // divider geometry
  localparam int QB     = 31;
  localparam int DIV_W  = G_W + FRAC_BITS;
  localparam int RI_W   = DIV_W - QB;
  localparam int REM_W  = S_W + 1;
  localparam int OVF_W  = G_W + QB - FRAC_BITS;

  localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_WALL_X   = 3'd0,
    REG_WALL_Y   = 3'd1,
    REG_WALL_Z   = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } cfg_reg_e;

  // operation codes
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_PERFORM = 1'b1;

  // values that ride along the divider
  typedef struct packed {
    logic               op;
    logic               ev;
    logic               ovf;
    logic [30:0]        last;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } swc_pass_t;

  // round half up from NORM_FRAC extra fraction bits and saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [RND_W-1:0] rnd;
    logic                    hi_ok;
    begin
      biased = acc + ACC_W'(signed'(1 << (NORM_FRAC - 1)));
      rnd    = biased[ACC_W-1:NORM_FRAC];
      hi_ok  = (rnd[RND_W-1:31] == '0) || (rnd[RND_W-1:31] == '1);
      if (hi_ok) begin
        round_sat = rnd[31:0];
      end else if (rnd[RND_W-1]) begin
        round_sat = 32'sh8000_0000;
      end else begin
        round_sat = 32'sh7FFF_FFFF;
      end
    end
  endfunction

endpackage

// ===== sv/swc_if.sv =====
// request and result channel interfaces of the sphere wall collision core
interface swc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] sphere_x;
  logic signed [31:0] sphere_y;
  logic signed [31:0] sphere_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [30:0]        radius;
  logic signed [31:0] growth_rate;
  logic [30:0]        last_update_time;

  modport source (output valid, operation, sphere_x, sphere_y, sphere_z, vel_x, vel_y,
                  vel_z, radius, growth_rate, last_update_time, input ready);
  modport sink (input valid, operation, sphere_x, sphere_y, sphere_z, vel_x, vel_y,
                vel_z, radius, growth_rate, last_update_time, output ready);
endinterface

interface swc_out_if;
  logic               valid;
  logic               ready;
  logic               has_event;
  logic [30:0]        event_time;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;

  modport source (output valid, has_event, event_time, new_vel_x, new_vel_y, new_vel_z,
                  input ready);
  modport sink (input valid, has_event, event_time, new_vel_x, new_vel_y, new_vel_z,
                output ready);
endinterface

// ===== sv/swc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module swc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  swc_pkg::swc_pass_t       in_pass,
  input  logic [swc_pkg::REM_W-1:0] in_rem,
  input  logic [swc_pkg::QB-1:0]    in_low,
  input  logic [swc_pkg::S_W-1:0]   in_div,
  output logic                     out_valid,
  output swc_pkg::swc_pass_t       out_pass,
  output logic [swc_pkg::QB-1:0]    out_quo
);
  import swc_pkg::*;

  logic              vld  [QB];
  swc_pass_t         pass [QB];
  logic [REM_W-1:0]  rem  [QB];
  logic [QB-1:0]     low  [QB];
  logic [S_W-1:0]    dvs  [QB];
  logic [QB-1:0]     quo  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic             src_v;
    swc_pass_t        src_p;
    logic [REM_W-1:0] src_rem;
    logic [QB-1:0]    src_low;
    logic [S_W-1:0]   src_div;
    logic [QB-1:0]    src_quo;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_p   = in_pass;
      assign src_rem = in_rem;
      assign src_low = in_low;
      assign src_div = in_div;
      assign src_quo = '0;
    end else begin : g_next
      assign src_v   = vld[k-1];
      assign src_p   = pass[k-1];
      assign src_rem = rem[k-1];
      assign src_low = low[k-1];
      assign src_div = dvs[k-1];
      assign src_quo = quo[k-1];
    end

    // shift in the next dividend bit and try the subtraction
    assign trial = {src_rem[REM_W-2:0], src_low[QB-1]};
    assign ge    = trial >= {1'b0, src_div};

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_v;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        pass[k] <= src_p;
        rem[k]  <= ge ? (trial - {1'b0, src_div}) : trial;
        low[k]  <= {src_low[QB-2:0], 1'b0};
        dvs[k]  <= src_div;
        quo[k]  <= {src_quo[QB-2:0], ge};
      end
    end
  end

  assign out_valid = vld[QB-1];
  assign out_pass  = pass[QB-1];
  assign out_quo   = quo[QB-1];

endmodule

// ===== sv/sphere_wall_collision_core.sv =====
// top level: growing sphere against plane wall, event time and collision response
// from request to result: 5 arithmetic stages, 31 divider stages and one output
// register; throughput: one request per cycle while the result side does not
// stall, set by the fully pipelined one-bit-per-stage divider. a stall at the
// result side holds the whole pipeline. synchronous reset clears all valid bits
// and loads the wall registers with point 0,0,0 and normal 0,0,1.
module sphere_wall_collision_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  swc_in_if.sink      req_in,
  swc_out_if.source   res_out
);
  import swc_pkg::*;

  logic signed [31:0] wall_x, wall_y, wall_z;
  logic signed [17:0] normal_x, normal_y, normal_z;
  logic               en;
  logic               out_v;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_x   <= '0;
      wall_y   <= '0;
      wall_z   <= '0;
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= 18'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WALL_X:   wall_x   <= cfg_data;
        REG_WALL_Y:   wall_y   <= cfg_data;
        REG_WALL_Z:   wall_z   <= cfg_data;
        REG_NORMAL_X: normal_x <= cfg_data[17:0];
        REG_NORMAL_Y: normal_y <= cfg_data[17:0];
        REG_NORMAL_Z: normal_z <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline advances unless the result register is held
  assign en           = !out_v || res_out.ready;
  assign req_in.ready = en;

  // stage 1: capture request, offsets from the wall point
  logic                     v1, op1;
  logic signed [DIFF_W-1:0] dx1, dy1, dz1;
  logic signed [31:0]       vx1, vy1, vz1, g1;
  logic [30:0]              r1, last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= req_in.operation;
      dx1   <= DIFF_W'(req_in.sphere_x) - DIFF_W'(wall_x);
      dy1   <= DIFF_W'(req_in.sphere_y) - DIFF_W'(wall_y);
      dz1   <= DIFF_W'(req_in.sphere_z) - DIFF_W'(wall_z);
      vx1   <= req_in.vel_x;
      vy1   <= req_in.vel_y;
      vz1   <= req_in.vel_z;
      g1    <= req_in.growth_rate;
      r1    <= req_in.radius;
      last1 <= req_in.last_update_time;
    end
  end

  // stage 2: products with the normal
  logic                   v2, op2;
  logic signed [PN_W-1:0] pnx2, pny2, pnz2;
  logic signed [VN_W-1:0] vnx2, vny2, vnz2;
  logic signed [GN_W-1:0] gnx2, gny2, gnz2;
  logic signed [31:0]     vx2, vy2, vz2, g2;
  logic [30:0]            r2, last2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2   <= op1;
      pnx2  <= PN_W'(normal_x) * PN_W'(dx1);
      pny2  <= PN_W'(normal_y) * PN_W'(dy1);
      pnz2  <= PN_W'(normal_z) * PN_W'(dz1);
      vnx2  <= VN_W'(normal_x) * VN_W'(vx1);
      vny2  <= VN_W'(normal_y) * VN_W'(vy1);
      vnz2  <= VN_W'(normal_z) * VN_W'(vz1);
      gnx2  <= GN_W'(normal_x) * GN_W'(g1);
      gny2  <= GN_W'(normal_y) * GN_W'(g1);
      gnz2  <= GN_W'(normal_z) * GN_W'(g1);
      vx2   <= vx1;
      vy2   <= vy1;
      vz2   <= vz1;
      g2    <= g1;
      r2    <= r1;
      last2 <= last1;
    end
  end

  // stage 3: gap, closing speed and v.n
  logic                     v3, op3;
  logic signed [GAP_W-1:0]  gap3;
  logic signed [SPD_W-1:0]  spd3;
  logic signed [VSUM_W-1:0] vn3;
  logic signed [GN_W-1:0]   gnx3, gny3, gnz3;
  logic signed [31:0]       vx3, vy3, vz3;
  logic [30:0]              last3;
  logic signed [VSUM_W-1:0] vsum2;

  assign vsum2 = VSUM_W'(vnx2) + VSUM_W'(vny2) + VSUM_W'(vnz2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3   <= op2;
      gap3  <= GAP_W'(pnx2) + GAP_W'(pny2) + GAP_W'(pnz2)
               - $signed(GAP_W'({r2, {NORM_FRAC{1'b0}}}));
      spd3  <= SPD_W'(vsum2) - SPD_W'($signed({g2, {NORM_FRAC{1'b0}}}));
      vn3   <= vsum2;
      gnx3  <= gnx2;
      gny3  <= gny2;
      gnz3  <= gnz2;
      vx3   <= vx2;
      vy3   <= vy2;
      vz3   <= vz2;
      last3 <= last2;
    end
  end

  // stage 4: event condition, divider operands, rounded v.n
  logic                    v4, op4, ev4, neg4;
  logic [G_W-1:0]          gg4;
  logic [S_W-1:0]          ss4;
  logic signed [VNQ_W-1:0] vnq4;
  logic signed [GN_W-1:0]  gnx4, gny4, gnz4;
  logic signed [31:0]      vx4, vy4, vz4;
  logic [30:0]             last4;
  logic signed [VSUM_W:0]  vn_bias3;
  logic [SPD_W-1:0]        spd_neg3;

  assign vn_bias3 = (VSUM_W+1)'(vn3) + (VSUM_W+1)'(signed'(1 << (NORM_FRAC - 1)));
  assign spd_neg3 = -spd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op4   <= op3;
      ev4   <= spd3[SPD_W-1] && !gap3[GAP_W-1];
      neg4  <= vn3[VSUM_W-1];
      gg4   <= gap3[G_W-1:0];
      ss4   <= spd_neg3[S_W-1:0];
      vnq4  <= vn_bias3[VSUM_W:NORM_FRAC];
      gnx4  <= gnx3;
      gny4  <= gny3;
      gnz4  <= gnz3;
      vx4   <= vx3;
      vy4   <= vy3;
      vz4   <= vz3;
      last4 <= last3;
    end
  end

  // stage 5: reflection products and time overflow test
  logic                    v5, op5, ev5, neg5, ovf5;
  logic [G_W-1:0]          gg5;
  logic [S_W-1:0]          ss5;
  logic signed [NVQ_W-1:0] nvx5, nvy5, nvz5;
  logic signed [GN_W-1:0]  gnx5, gny5, gnz5;
  logic signed [31:0]      vx5, vy5, vz5;
  logic [30:0]             last5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op5   <= op4;
      ev5   <= ev4;
      neg5  <= neg4;
      ovf5  <= OVF_W'(gg4) >= (OVF_W'(ss4) << (QB - FRAC_BITS));
      gg5   <= gg4;
      ss5   <= ss4;
      nvx5  <= NVQ_W'(normal_x) * NVQ_W'(vnq4);
      nvy5  <= NVQ_W'(normal_y) * NVQ_W'(vnq4);
      nvz5  <= NVQ_W'(normal_z) * NVQ_W'(vnq4);
      gnx5  <= gnx4;
      gny5  <= gny4;
      gnz5  <= gnz4;
      vx5   <= vx4;
      vy5   <= vy4;
      vz5   <= vz4;
      last5 <= last4;
    end
  end

  // new velocity components, rounded and saturated on entry to the divider
  logic signed [ACC_W-1:0] accx, accy, accz;
  swc_pass_t               pass5;
  logic [DIV_W-1:0]        dividend5;

  always_comb begin
    accx = ACC_W'($signed({vx5, {NORM_FRAC{1'b0}}})) + ACC_W'(gnx5);
    accy = ACC_W'($signed({vy5, {NORM_FRAC{1'b0}}})) + ACC_W'(gny5);
    accz = ACC_W'($signed({vz5, {NORM_FRAC{1'b0}}})) + ACC_W'(gnz5);
    if (neg5) begin
      accx = accx - (ACC_W'(nvx5) <<< 1);
      accy = accy - (ACC_W'(nvy5) <<< 1);
      accz = accz - (ACC_W'(nvz5) <<< 1);
    end
    pass5.op   = op5;
    pass5.ev   = ev5;
    pass5.ovf  = ovf5;
    pass5.last = last5;
    pass5.vx   = round_sat(accx);
    pass5.vy   = round_sat(accy);
    pass5.vz   = round_sat(accz);
  end

  assign dividend5 = {gg5, {FRAC_BITS{1'b0}}};

  // time quotient, one bit per stage
  logic             vd;
  swc_pass_t        passd;
  logic [QB-1:0]    quod;

  swc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_pass   (pass5),
    .in_rem    (REM_W'(dividend5[DIV_W-1:QB])),
    .in_low    (dividend5[QB-1:0]),
    .in_div    (ss5),
    .out_valid (vd),
    .out_pass  (passd),
    .out_quo   (quod)
  );

  // output register: absolute time with saturation, or the new velocity
  logic [31:0]        tsum;
  logic               has_event_next;
  logic [30:0]        event_time_next;
  logic signed [31:0] new_vel_x_next, new_vel_y_next, new_vel_z_next;

  assign tsum = {1'b0, passd.last} + {1'b0, quod};

  always_comb begin
    has_event_next  = 1'b0;
    event_time_next = '0;
    new_vel_x_next  = '0;
    new_vel_y_next  = '0;
    new_vel_z_next  = '0;
    if (passd.op == OP_PERFORM) begin
      new_vel_x_next = passd.vx;
      new_vel_y_next = passd.vy;
      new_vel_z_next = passd.vz;
    end else if (passd.ev) begin
      has_event_next  = 1'b1;
      event_time_next = (passd.ovf || tsum[31]) ? TIME_MAX : tsum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out.has_event  <= has_event_next;
      res_out.event_time <= event_time_next;
      res_out.new_vel_x  <= new_vel_x_next;
      res_out.new_vel_y  <= new_vel_y_next;
      res_out.new_vel_z  <= new_vel_z_next;
    end
  end

  assign res_out.valid = out_v;

`ifndef SYNTHESIS
  a_no_event_zero_time: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.has_event && res_out.event_time != '0 |-> 1'b0)
    else $error("event time set without an event");

  a_event_no_velocity: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.has_event |->
      res_out.new_vel_x == '0 && res_out.new_vel_y == '0 && res_out.new_vel_z == '0)
    else $error("velocity set on a predict result");

  a_valid_moves: assert property (@(posedge clk) disable iff (rst)
    en && v1 |=> v2)
    else $error("valid bit lost between stages");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_out.valid)
    else $error("result valid right after reset");
`endif

endmodule
